// ===== hdl/assert_macros.svh =====
// Assertion macros used by serial_frame_receiver.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPLIES(label, clk_sig, rst_n_sig, cond, expr) \
	label: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) (cond) |-> (expr)) \
		else $error("assertion failed");
`define ASSERT_NEXT(label, clk_sig, rst_n_sig, cond, expr) \
	label: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) (cond) |=> (expr)) \
		else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk_sig, rst_n_sig, cond, expr)
`define ASSERT_NEXT(label, clk_sig, rst_n_sig, cond, expr)
`endif
`endif

// ===== hdl/sfr_pkg.sv =====
// Types, constants and phase codes of the serial frame receiver.
package sfr_pkg;
	localparam int PAYLOAD_BYTES = 8;
	localparam int IDX_W = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
	localparam int CFG_IDX_W = 3;
	localparam int OUT_W = 80;

	localparam logic [CFG_IDX_W-1:0] REG_HEADER_FIRST  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEADER_SECOND = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_ID    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TRAILER_FIRST = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TRAILER_SECOND = 3'd4;

	localparam logic [3:0] PH_HEAD1 = 4'd0;
	localparam logic [3:0] PH_HEAD2 = 4'd1;
	localparam logic [3:0] PH_CID   = 4'd2;
	localparam logic [3:0] PH_FC    = 4'd3;
	localparam logic [3:0] PH_SFC   = 4'd4;
	localparam logic [3:0] PH_DATA  = 4'd5;
	localparam logic [3:0] PH_SUMH  = 4'd6;
	localparam logic [3:0] PH_SUML  = 4'd7;
	localparam logic [3:0] PH_TAIL1 = 4'd8;
	localparam logic [3:0] PH_TAIL2 = 4'd9;

	typedef struct packed {
		logic [7:0] header_first;
		logic [7:0] header_second;
		logic [7:0] channel_id;
		logic [7:0] trailer_first;
		logic [7:0] trailer_second;
	} sfr_cfg_t;

	typedef struct packed {
		logic [63:0] payload;
		logic [7:0]  subfunction_code;
		logic [7:0]  function_code;
	} sfr_result_t;
endpackage

// ===== hdl/serial_frame_receiver.sv =====
// Last tail byte: input register, then parser, then output register driving m_tvalid.
// Throughput: one byte per cycle; the parser consumes the byte held in the input register, and
// only a byte that completes a frame waits on a held result.
// Reset (arst_n low, asynchronous): parser hunts for the first header, registers
// return to their defaults, input and output registers empty.
`include "assert_macros.svh"
module serial_frame_receiver
	import sfr_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [7:0]           s_tdata,   // [7:0] rx_byte
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [OUT_W-1:0]     m_tdata,   // [7:0] function_code, [15:8] subfunction_code,
	                                        // [79:16] payload
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]           cfg_data
);
	sfr_cfg_t    cfg;
	sfr_result_t result;
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        emit, step, out_free;
	logic        m_valid_q;
	logic [OUT_W-1:0] m_data_q;

	sfr_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	sfr_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.rx_byte (byte_s1),
		.step    (step),
		.emit    (emit),
		.result  (result)
	);

	assign out_free = !m_valid_q || m_tready;
	// a non-completing byte never has to wait for the result register
	assign step     = valid_s1 && (out_free || !emit);
	assign s_tready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready)
			byte_s1 <= s_tdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (step && emit) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && emit)
			m_data_q <= {result.payload, result.subfunction_code, result.function_code};
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

	`ASSERT_IMPLIES(a_no_overwrite, clk, arst_n, m_valid_q && !m_tready, !(step && emit))
	`ASSERT_NEXT(a_emit_shows, clk, arst_n, step && emit, m_valid_q)
	`ASSERT_NEXT(a_s1_holds, clk, arst_n, valid_s1 && !step, valid_s1 && $stable(byte_s1))
endmodule

// ===== hdl/sfr_cfg_regs.sv =====
// Configuration register file of the serial frame receiver.
module sfr_cfg_regs
	import sfr_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]           cfg_data,
	output sfr_cfg_t             cfg
);
	sfr_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.header_first   <= 8'hAA;
			cfg_q.header_second  <= 8'hBB;
			cfg_q.channel_id     <= 8'h00;
			cfg_q.trailer_first  <= 8'h00;
			cfg_q.trailer_second <= 8'h00;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_HEADER_FIRST:   cfg_q.header_first   <= cfg_data;
				REG_HEADER_SECOND:  cfg_q.header_second  <= cfg_data;
				REG_CHANNEL_ID:     cfg_q.channel_id     <= cfg_data;
				REG_TRAILER_FIRST:  cfg_q.trailer_first  <= cfg_data;
				REG_TRAILER_SECOND: cfg_q.trailer_second <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;
endmodule

// ===== hdl/sfr_parser.sv =====
// Frame parser: phase machine, checksum accumulator and payload store.
module sfr_parser
	import sfr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  sfr_cfg_t    cfg,
	input  logic [7:0]  rx_byte,
	input  logic        step,
	output logic        emit,
	output sfr_result_t result
);
	logic [3:0]  phase_q, phase_nxt;
	logic [IDX_W-1:0] idx_q;
	logic [15:0] sum_q;
	logic [7:0]  sum_high_q;
	logic [7:0]  fc_q, sfc_q;
	logic [PAYLOAD_BYTES-1:0][7:0] store_q;
	logic [15:0] sum_add;

	assign sum_add = sum_q + {8'd0, rx_byte};

	always_comb begin
		phase_nxt = phase_q;
		emit      = 1'b0;
		unique case (phase_q)
			PH_HEAD1: if (rx_byte == cfg.header_first) phase_nxt = PH_HEAD2;
			PH_HEAD2: phase_nxt = (rx_byte == cfg.header_second) ? PH_CID : PH_HEAD1;
			PH_CID:   phase_nxt = (rx_byte == cfg.channel_id) ? PH_FC : PH_HEAD1;
			PH_FC:    phase_nxt = PH_SFC;
			PH_SFC:   phase_nxt = PH_DATA;
			PH_DATA:  if (idx_q == IDX_W'(PAYLOAD_BYTES - 1)) phase_nxt = PH_SUMH;
			PH_SUMH:  phase_nxt = PH_SUML;
			PH_SUML:  phase_nxt = ({sum_high_q, rx_byte} == sum_q) ? PH_TAIL1 : PH_HEAD1;
			PH_TAIL1: phase_nxt = (rx_byte == cfg.trailer_first) ? PH_TAIL2 : PH_HEAD1;
			PH_TAIL2: begin
				emit      = (rx_byte == cfg.trailer_second);
				phase_nxt = PH_HEAD1;
			end
			default:  phase_nxt = PH_HEAD1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEAD1;
			idx_q   <= '0;
		end else if (step) begin
			phase_q <= phase_nxt;
			if (phase_q == PH_SFC)
				idx_q <= '0;
			else if (phase_q == PH_DATA)
				idx_q <= idx_q + IDX_W'(1);
		end
	end

	// datapath registers: only read after being written in the same frame
	always_ff @(posedge clk) begin
		if (step) begin
			unique case (phase_q)
				PH_CID:  sum_q <= {8'd0, rx_byte};
				PH_FC: begin
					fc_q  <= rx_byte;
					sum_q <= sum_add;
				end
				PH_SFC: begin
					sfc_q <= rx_byte;
					sum_q <= sum_add;
				end
				PH_DATA: begin
					store_q[idx_q] <= rx_byte;
					sum_q          <= sum_add;
				end
				PH_SUMH: sum_high_q <= rx_byte;
				default: ;
			endcase
		end
	end

	assign result.function_code    = fc_q;
	assign result.subfunction_code = sfc_q;
	assign result.payload          = 64'(store_q);
endmodule

// ===== sim/tb_serial_frame_receiver.sv =====
// Testbench of the serial frame receiver: byte stream in, frames predicted and checked at the output.
`timescale 1ns / 100ps

module tb_serial_frame_receiver;
	import sfr_pkg::*;

	localparam int FRAME_LEN     = PAYLOAD_BYTES + 9;
	localparam int SUM_POS       = PAYLOAD_BYTES + 5;
	localparam int SETTLE_CYCLES = 4;
	localparam int HOLD_CYCLES   = 300;
	localparam int STUCK_LIMIT   = 4000;

	typedef enum int {
		FLAW_NONE, FLAW_HEAD2, FLAW_CHANNEL, FLAW_SUM_HIGH, FLAW_SUM_LOW,
		FLAW_TAIL1, FLAW_TAIL2, FLAW_CUT
	} flaw_t;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [7:0]           s_tdata;   // [7:0] rx_byte
	logic                 m_tvalid;
	logic                 m_tready;
	logic [OUT_W-1:0]     m_tdata;   // [7:0] function_code, [15:8] subfunction_code,
	                                 // [79:16] payload
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [7:0]           cfg_data;

	serial_frame_receiver DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// deframer prediction state
	sfr_cfg_t    regs;
	logic [3:0]  rx_phase;
	logic [7:0]  held_fc;
	logic [7:0]  held_sfc;
	logic [7:0]  pay_store [8];
	int          pay_count;
	logic [15:0] sum_acc;
	logic [7:0]  sum_high;
	sfr_result_t frames_due [$];

	int src_gap_pct;
	int snk_stall_pct;
	int hold_left;
	int mismatch_count;
	int quiet_cycles;
	int frame_bytes_sent;

	initial clk = 1'b0;
	always #1 clk = ~clk;

	function automatic void deframe_byte(input logic [7:0] b);
		sfr_result_t r;
		case (rx_phase)
			PH_HEAD1: if (b == regs.header_first) rx_phase = PH_HEAD2;
			PH_HEAD2: rx_phase = (b == regs.header_second) ? PH_CID : PH_HEAD1;
			PH_CID: begin
				if (b == regs.channel_id) begin
					sum_acc = {8'h00, b};
					rx_phase = PH_FC;
				end else begin
					rx_phase = PH_HEAD1;
				end
			end
			PH_FC: begin
				held_fc = b;
				sum_acc = sum_acc + {8'h00, b};
				rx_phase = PH_SFC;
			end
			PH_SFC: begin
				held_sfc = b;
				sum_acc = sum_acc + {8'h00, b};
				pay_count = 0;
				rx_phase = PH_DATA;
			end
			PH_DATA: begin
				pay_store[pay_count] = b;
				sum_acc = sum_acc + {8'h00, b};
				pay_count++;
				if (pay_count >= PAYLOAD_BYTES) rx_phase = PH_SUMH;
			end
			PH_SUMH: begin
				sum_high = b;
				rx_phase = PH_SUML;
			end
			PH_SUML: rx_phase = ({sum_high, b} == sum_acc) ? PH_TAIL1 : PH_HEAD1;
			PH_TAIL1: rx_phase = (b == regs.trailer_first) ? PH_TAIL2 : PH_HEAD1;
			PH_TAIL2: begin
				if (b == regs.trailer_second) begin
					r.function_code = held_fc;
					r.subfunction_code = held_sfc;
					r.payload = '0;
					for (int i = 0; i < PAYLOAD_BYTES; i++) r.payload[8*i +: 8] = pay_store[i];
					frames_due.push_back(r);
				end
				rx_phase = PH_HEAD1;
			end
			default: rx_phase = PH_HEAD1;
		endcase
	endfunction

	function automatic logic [7:0] pick_byte();
		int roll;
		roll = $urandom_range(9);
		if (roll == 0) return 8'h00;
		if (roll == 1) return 8'hFF;
		return 8'($urandom_range(255));
	endfunction

	function automatic logic [63:0] pick_payload();
		logic [63:0] p;
		for (int i = 0; i < 8; i++) p[8*i +: 8] = pick_byte();
		return p;
	endfunction

	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < src_gap_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		do @(posedge clk); while (!s_tready);
		deframe_byte(b);
	endtask

	// builds a frame from the current register values, spoils one byte or cuts it short if asked
	task automatic send_frame(input logic [7:0] fc, input logic [7:0] sfc,
			input logic [63:0] pl, input flaw_t flaw, input int start_at = 0);
		logic [7:0]  seq [FRAME_LEN];
		logic [15:0] sum;
		logic [7:0]  spoil;
		int          cut;
		sum = {8'h00, regs.channel_id} + {8'h00, fc} + {8'h00, sfc};
		for (int i = 0; i < PAYLOAD_BYTES; i++) begin
			seq[5 + i] = pl[8*i +: 8];
			sum = sum + {8'h00, pl[8*i +: 8]};
		end
		seq[0] = regs.header_first;
		seq[1] = regs.header_second;
		seq[2] = regs.channel_id;
		seq[3] = fc;
		seq[4] = sfc;
		seq[SUM_POS]     = sum[15:8];
		seq[SUM_POS + 1] = sum[7:0];
		seq[SUM_POS + 2] = regs.trailer_first;
		seq[SUM_POS + 3] = regs.trailer_second;
		spoil = 8'($urandom_range(1, 255));
		cut = FRAME_LEN;
		case (flaw)
			FLAW_HEAD2:    seq[1] ^= spoil;
			FLAW_CHANNEL:  seq[2] ^= spoil;
			FLAW_SUM_HIGH: seq[SUM_POS] ^= spoil;
			FLAW_SUM_LOW:  seq[SUM_POS + 1] ^= spoil;
			FLAW_TAIL1:    seq[SUM_POS + 2] ^= spoil;
			FLAW_TAIL2:    seq[SUM_POS + 3] ^= spoil;
			FLAW_CUT:      cut = $urandom_range(1, FRAME_LEN - 1);
			default: ;
		endcase
		for (int i = start_at; i < cut; i++) begin
			send_byte(seq[i]);
			frame_bytes_sent++;
		end
	endtask

	// stop sending, let every predicted frame arrive and the parser go quiet
	task automatic settle();
		s_tvalid <= 1'b0;
		while (frames_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_HEADER_FIRST:   regs.header_first = val;
			REG_HEADER_SECOND:  regs.header_second = val;
			REG_CHANNEL_ID:     regs.channel_id = val;
			REG_TRAILER_FIRST:  regs.trailer_first = val;
			REG_TRAILER_SECOND: regs.trailer_second = val;
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic program_regs(input logic [7:0] hf, input logic [7:0] hs,
			input logic [7:0] cid, input logic [7:0] tf, input logic [7:0] ts);
		write_reg(REG_HEADER_FIRST, hf);
		write_reg(REG_HEADER_SECOND, hs);
		write_reg(REG_CHANNEL_ID, cid);
		write_reg(REG_TRAILER_FIRST, tf);
		write_reg(REG_TRAILER_SECOND, ts);
	endtask

	task automatic test_directed_frames();
		send_frame(8'h00, 8'h00, 64'h0, FLAW_NONE);
		send_frame(8'hFF, 8'hFF, '1, FLAW_NONE);
		send_frame(8'h01, 8'h80, 64'h8040_2010_0804_0201, FLAW_NONE);
		// every kind of broken frame, each followed by a clean one
		for (int f = FLAW_HEAD2; f <= FLAW_CUT; f++) begin
			send_frame(pick_byte(), pick_byte(), pick_payload(), flaw_t'(f));
			send_frame(pick_byte(), pick_byte(), pick_payload(), FLAW_NONE);
		end
		// bytes that are not a first header are skipped
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'h55);
		send_frame(8'h12, 8'h34, pick_payload(), FLAW_NONE);
		// a rejected byte equal to the first header must not restart the hunt
		send_byte(regs.header_first);
		send_byte(regs.header_first);
		send_frame(8'h56, 8'h78, pick_payload(), FLAW_NONE);
		send_byte(regs.header_first);
		send_byte(regs.header_second);
		send_byte(regs.header_first);
		send_frame(8'h9A, 8'hBC, pick_payload(), FLAW_NONE);
		settle();
	endtask

	task automatic test_register_extremes();
		program_regs(8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
		send_frame(8'h00, 8'h00, 64'h0, FLAW_NONE);
		send_frame(pick_byte(), pick_byte(), pick_payload(), FLAW_TAIL2);
		send_frame(pick_byte(), pick_byte(), pick_payload(), FLAW_NONE);
		settle();
		program_regs(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
		send_frame(8'hFF, 8'hFF, '1, FLAW_NONE);
		send_frame(pick_byte(), pick_byte(), pick_payload(), FLAW_NONE);
		settle();
		program_regs(8'h3C, 8'hC3, 8'h7E, 8'h0D, 8'h0A);
		// writes above the last register index change nothing
		for (int idx = REG_TRAILER_SECOND + 1; idx < 2**CFG_IDX_W; idx++)
			write_reg(idx[CFG_IDX_W-1:0], 8'($urandom_range(255)));
		send_frame(pick_byte(), pick_byte(), pick_payload(), FLAW_NONE);
		settle();
	endtask

	// parser left part-way through a frame while the registers change
	task automatic test_midframe_writes();
		send_byte(regs.header_first);
		settle();
		write_reg(REG_HEADER_SECOND, 8'h5A);
		send_frame(8'h21, 8'h43, pick_payload(), FLAW_NONE, 1);
		send_byte(regs.header_first);
		send_byte(regs.header_second);
		settle();
		write_reg(REG_CHANNEL_ID, 8'hA5);
		send_frame(8'h65, 8'h87, pick_payload(), FLAW_NONE, 2);
		settle();
	endtask

	task automatic test_back_pressure();
		hold_left = HOLD_CYCLES;
		repeat (6) send_frame(pick_byte(), pick_byte(), pick_payload(), FLAW_NONE);
		settle();
	endtask

	task automatic test_random_traffic(input int gap, input int stall, input int n_bytes);
		int target;
		int roll;
		src_gap_pct = gap;
		snk_stall_pct = stall;
		target = frame_bytes_sent + n_bytes;
		while (frame_bytes_sent < target) begin
			roll = $urandom_range(99);
			if (roll < 65)
				send_frame(pick_byte(), pick_byte(), pick_payload(), FLAW_NONE);
			else if (roll < 85)
				send_frame(pick_byte(), pick_byte(), pick_payload(),
					flaw_t'($urandom_range(FLAW_HEAD2, FLAW_CUT)));
			else
				repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(255)));
		end
		settle();
	endtask

	// result side: random stalls, long hold-off on request, checks every transaction
	always @(posedge clk) begin
		sfr_result_t got;
		sfr_result_t want;
		if (m_tvalid && m_tready) begin
			got = m_tdata;
			if (frames_due.size() == 0) begin
				$display("%0t: frame %h arrived with none expected", $time, m_tdata);
				mismatch_count++;
			end else begin
				want = frames_due.pop_front();
				if (got.function_code != want.function_code) begin
					$display("%0t: function_code expected %h got %h", $time,
						want.function_code, got.function_code);
					mismatch_count++;
				end
				if (got.subfunction_code != want.subfunction_code) begin
					$display("%0t: subfunction_code expected %h got %h", $time,
						want.subfunction_code, got.subfunction_code);
					mismatch_count++;
				end
				if (got.payload != want.payload) begin
					$display("%0t: payload expected %h got %h", $time,
						want.payload, got.payload);
					mismatch_count++;
				end
			end
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= snk_stall_pct);
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STUCK_LIMIT) begin
			$display("serial_frame_receiver regression: fail");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = 8'h00;
		m_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_HEADER_FIRST;
		cfg_data = 8'h00;
		regs.header_first = 8'hAA;
		regs.header_second = 8'hBB;
		regs.channel_id = 8'h00;
		regs.trailer_first = 8'h00;
		regs.trailer_second = 8'h00;
		rx_phase = PH_HEAD1;
		held_fc = 8'h00;
		held_sfc = 8'h00;
		pay_count = 0;
		sum_acc = 16'h0000;
		sum_high = 8'h00;
		hold_left = 0;
		mismatch_count = 0;
		quiet_cycles = 0;
		frame_bytes_sent = 0;
		src_gap_pct = 37;
		snk_stall_pct = 65;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_frames();
		test_register_extremes();
		test_midframe_writes();
		program_regs(8'($urandom_range(255)), 8'($urandom_range(255)),
			8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)));
		test_random_traffic(37, 65, 400);
		program_regs(8'h00, 8'hFF, 8'hFF, 8'h00, 8'hFF);
		test_random_traffic(65, 37, 400);
		src_gap_pct = 0;
		snk_stall_pct = 0;
		test_back_pressure();
		program_regs(8'($urandom_range(255)), 8'($urandom_range(255)),
			8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)));
		test_random_traffic(0, 0, 400);

		settle();
		if (mismatch_count == 0)
			$display("serial_frame_receiver regression: pass");
		else
			$display("serial_frame_receiver regression: fail");
		$finish;
	end
endmodule

// ===== sim.f =====
+incdir+hdl
hdl/sfr_pkg.sv
hdl/sfr_cfg_regs.sv
hdl/sfr_parser.sv
hdl/serial_frame_receiver.sv
sim/tb_serial_frame_receiver.sv
